// ===== rtl/vdda_pkg.sv =====
package vdda_pkg;

    localparam int DEFAULT_SCREEN_SIZE = 1024;

    // Restoring dividers: 16 quotient bits, one per cycle
    localparam int DIV_ITERS = 16;
    localparam int CNT_W     = $clog2(DIV_ITERS);

    localparam logic [7:0] SCALE_RESET = 8'd1;

    localparam logic OP_VECTOR = 1'b0;
    localparam logic OP_STEP   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_SIGN,
        ST_DIFF,
        ST_SETUP,
        ST_INC,
        ST_FIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic vec;
        logic step;
        logic scale_iter;
        logic sign;
        logic diff;
        logic setup;
        logic inc_iter;
        logic fin;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic draw;
        logic steps_zero;
        logic out_free;
    } t_status;

    function automatic logic [15:0] abs16(input logic [15:0] v);
        return v[15] ? 16'(~v + 16'd1) : v;
    endfunction

    // Q16.16 to integer, truncating toward zero
    function automatic logic [15:0] pen_int(input logic [31:0] p);
        return p[31:16] + {15'd0, p[31] && (p[15:0] != 16'd0)};
    endfunction

endpackage

// ===== rtl/vdda_ctrl.sv =====
module vdda_ctrl
    import vdda_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_op,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_stall
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_cnt_last;

    assign w_cnt_last = (r_cnt == CNT_W'(DIV_ITERS - 1));
    assign o_stall    = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        n_cnt   = (r_state == ST_SCALE || r_state == ST_INC) ? r_cnt + 1'b1 : '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_op == OP_STEP) begin
                        if (!i_status.steps_zero) begin
                            o_cmd.step = 1'b1;
                            n_state    = ST_EMIT;
                        end
                    end else begin
                        o_cmd.vec = 1'b1;
                        if (i_status.draw) begin
                            n_state = ST_SCALE;
                        end
                    end
                end
            end
            ST_SCALE: begin
                o_cmd.scale_iter = 1'b1;
                if (w_cnt_last) begin
                    n_state = ST_SIGN;
                end
            end
            ST_SIGN: begin
                o_cmd.sign = 1'b1;
                n_state    = ST_DIFF;
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = ST_SETUP;
            end
            ST_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = ST_INC;
            end
            ST_INC: begin
                o_cmd.inc_iter = 1'b1;
                if (w_cnt_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/vdda_datapath.sv =====
module vdda_datapath
    import vdda_pkg::*;
#(
    parameter int SCREEN_SIZE = DEFAULT_SCREEN_SIZE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic signed [12:0] i_delta_x,
    input  logic signed [12:0] i_delta_y,
    input  logic [7:0]         i_intensity,
    input  logic               i_scale_we,
    input  logic [7:0]         i_scale_wdata,
    input  logic               i_stall,
    output logic               o_valid,
    output logic signed [15:0] o_pixel_x,
    output logic signed [15:0] o_pixel_y,
    output logic [7:0]         o_pixel_intensity,
    output logic               o_on_screen,
    output logic               o_last
);

    localparam int HALF = SCREEN_SIZE / 2;

    logic [7:0]  r_scale;
    logic [15:0] r_beam_x, r_beam_y;
    logic [31:0] r_pen_x, r_pen_y;
    logic [17:0] r_step_x, r_step_y;
    logic [15:0] r_steps_left;
    logic [7:0]  r_line_int;
    logic        r_valid;

    // scale divider lanes: 0 x1, 1 y1, 2 x2, 3 y2
    logic [15:0] r_sq   [4];
    logic [7:0]  r_sr   [4];
    logic        r_sneg [4];
    logic [16:0] r_sv   [4];

    logic [15:0] r_ax, r_ay;
    logic        r_xneg, r_yneg;
    logic [15:0] r_div_step;

    // increment divider lanes: 0 x, 1 y
    logic [16:0] r_iq [2];
    logic [15:0] r_ir [2];

    logic [15:0] w_new_x, w_new_y;
    logic [15:0] w_dvd [4];
    logic [8:0]  w_div;
    logic [8:0]  w_st  [4];
    logic [7:0]  w_snr [4];
    logic        w_sge [4];
    logic        w_xlt, w_ylt;
    logic [15:0] w_step;
    logic [16:0] w_it  [2];
    logic        w_ige [2];
    logic [15:0] w_inr [2];
    logic [16:0] w_q   [2];
    logic [15:0] w_px, w_py;
    logic [17:0] w_xp, w_yp;
    logic        w_on;

    assign w_new_x = r_beam_x + {{3{i_delta_x[12]}}, i_delta_x};
    assign w_new_y = r_beam_y + {{3{i_delta_y[12]}}, i_delta_y};

    assign w_dvd[0] = abs16(r_beam_x);
    assign w_dvd[1] = abs16(r_beam_y);
    assign w_dvd[2] = abs16(w_new_x);
    assign w_dvd[3] = abs16(w_new_y);

    assign w_div = (r_scale == 8'd0) ? 9'd1 : {1'b0, r_scale};

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_st[i]  = {r_sr[i], r_sq[i][15]};
            w_sge[i] = (w_st[i] >= w_div);
            w_snr[i] = w_sge[i] ? 8'(w_st[i] - w_div) : w_st[i][7:0];
        end
        for (int k = 0; k < 2; k++) begin
            w_it[k]  = {r_ir[k], 1'b0};
            w_ige[k] = (w_it[k] >= {1'b0, r_div_step});
            w_inr[k] = w_ige[k] ? 16'(w_it[k] - {1'b0, r_div_step}) : w_it[k][15:0];
            w_q[k]   = (r_div_step == 16'd0) ? 17'd0 : r_iq[k];
        end
    end

    assign w_xlt  = $signed(r_sv[2]) < $signed(r_sv[0]);
    assign w_ylt  = $signed(r_sv[3]) < $signed(r_sv[1]);
    assign w_step = (r_ax > r_ay) ? r_ax : r_ay;

    assign w_px = pen_int(r_pen_x);
    assign w_py = pen_int(r_pen_y);
    assign w_xp = {{2{w_px[15]}}, w_px} + 18'(HALF);
    assign w_yp = {{2{w_py[15]}}, w_py} + 18'(HALF);
    assign w_on = !w_xp[17] && (w_xp[16:0] < 17'(SCREEN_SIZE))
               && !w_yp[17] && (w_yp[16:0] < 17'(SCREEN_SIZE));

    assign o_status.draw       = (i_intensity != 8'd0);
    assign o_status.steps_zero = (r_steps_left == 16'd0);
    assign o_status.out_free   = !r_valid || !i_stall;
    assign o_valid             = r_valid;

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale      <= SCALE_RESET;
            r_beam_x     <= '0;
            r_beam_y     <= '0;
            r_pen_x      <= '0;
            r_pen_y      <= '0;
            r_step_x     <= '0;
            r_step_y     <= '0;
            r_steps_left <= '0;
            r_line_int   <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (i_scale_we) begin
                r_scale <= i_scale_wdata;
            end
            if (i_cmd.vec) begin
                r_beam_x     <= w_new_x;
                r_beam_y     <= w_new_y;
                r_steps_left <= '0;
                if (i_intensity != 8'd0) begin
                    r_line_int <= i_intensity;
                end
            end
            if (i_cmd.setup) begin
                r_steps_left <= w_step;
                r_pen_x      <= {r_sv[0][15:0], 16'd0};
                r_pen_y      <= {r_sv[1][15:0], 16'd0};
            end
            if (i_cmd.fin) begin
                r_step_x <= r_xneg ? 18'(-{1'b0, w_q[0]}) : {1'b0, w_q[0]};
                r_step_y <= r_yneg ? 18'(-{1'b0, w_q[1]}) : {1'b0, w_q[1]};
            end
            if (i_cmd.step) begin
                r_pen_x      <= r_pen_x + {{14{r_step_x[17]}}, r_step_x};
                r_pen_y      <= r_pen_y + {{14{r_step_y[17]}}, r_step_y};
                r_steps_left <= r_steps_left - 16'd1;
            end
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // divider lanes and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.vec) begin
            for (int i = 0; i < 4; i++) begin
                r_sq[i] <= w_dvd[i];
                r_sr[i] <= '0;
            end
            r_sneg[0] <= r_beam_x[15];
            r_sneg[1] <= r_beam_y[15];
            r_sneg[2] <= w_new_x[15];
            r_sneg[3] <= w_new_y[15];
        end
        if (i_cmd.scale_iter) begin
            for (int i = 0; i < 4; i++) begin
                r_sq[i] <= {r_sq[i][14:0], w_sge[i]};
                r_sr[i] <= w_snr[i];
            end
        end
        if (i_cmd.sign) begin
            for (int i = 0; i < 4; i++) begin
                r_sv[i] <= r_sneg[i] ? 17'(-{1'b0, r_sq[i]}) : {1'b0, r_sq[i]};
            end
        end
        if (i_cmd.diff) begin
            r_xneg <= w_xlt;
            r_yneg <= w_ylt;
            r_ax   <= w_xlt ? 16'(r_sv[0] - r_sv[2]) : 16'(r_sv[2] - r_sv[0]);
            r_ay   <= w_ylt ? 16'(r_sv[1] - r_sv[3]) : 16'(r_sv[3] - r_sv[1]);
        end
        if (i_cmd.setup) begin
            r_div_step <= w_step;
            // integer bit set when |d| equals the major axis length
            r_iq[0]    <= {16'd0, r_ax == w_step};
            r_iq[1]    <= {16'd0, r_ay == w_step};
            r_ir[0]    <= (r_ax == w_step) ? 16'd0 : r_ax;
            r_ir[1]    <= (r_ay == w_step) ? 16'd0 : r_ay;
        end
        if (i_cmd.inc_iter) begin
            for (int k = 0; k < 2; k++) begin
                r_iq[k] <= {r_iq[k][15:0], w_ige[k]};
                r_ir[k] <= w_inr[k];
            end
        end
        if (i_cmd.emit) begin
            o_pixel_x         <= w_px;
            o_pixel_y         <= w_py;
            o_pixel_intensity <= r_line_int;
            o_on_screen       <= w_on;
            o_last            <= (r_steps_left == 16'd0);
        end
    end

endmodule

// ===== rtl/vector_dda_line_rasterizer.sv =====
// Vector DDA line rasterizer.
// Input channel (i_valid / o_stall): i_op = OP_VECTOR moves the beam by
// i_delta_x/i_delta_y; with nonzero i_intensity it starts a new line and sends
// its first pixel. i_op = OP_STEP sends the next pixel of the current line,
// or nothing when no line is active. Any vector abandons an unfinished line.
// Output channel (o_valid / i_stall): one pixel per producing item, o_last
// marks the final pixel of a line.
// Scale register: i_scale_we / i_scale_wdata, write only while the block is idle.
// Sequence: a drawing vector passes its pixel to o_valid after two restoring
// dividers in series (scale divide on four lanes, then the Q2.16 increment divide
// on two lanes). A step item goes straight to the emit state; a vector without
// intensity, or a step with no line, is taken without leaving idle.
// One item is in work at a time; o_stall is high while it is.
// A finished pixel sits in the output register while the next item is taken;
// if the receiver stalls, the following pixel waits in the emit state until
// the register frees, and inputs stall meanwhile.
// Reset: beam, pen, increments and line state clear, scale returns to 1,
// no output is pending.
module vector_dda_line_rasterizer
    import vdda_pkg::*;
#(
    parameter int SCREEN_SIZE = DEFAULT_SCREEN_SIZE
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_op,
    input  logic signed [12:0] i_delta_x,
    input  logic signed [12:0] i_delta_y,
    input  logic [7:0]         i_intensity,
    input  logic               i_scale_we,
    input  logic [7:0]         i_scale_wdata,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_pixel_x,
    output logic signed [15:0] o_pixel_y,
    output logic [7:0]         o_pixel_intensity,
    output logic               o_on_screen,
    output logic               o_last
);

    t_cmd    w_cmd;
    t_status w_status;

    vdda_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_op     (i_op),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_stall  (o_stall)
    );

    vdda_datapath #(
        .SCREEN_SIZE (SCREEN_SIZE)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_delta_x         (i_delta_x),
        .i_delta_y         (i_delta_y),
        .i_intensity       (i_intensity),
        .i_scale_we        (i_scale_we),
        .i_scale_wdata     (i_scale_wdata),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_pixel_x         (o_pixel_x),
        .o_pixel_y         (o_pixel_y),
        .o_pixel_intensity (o_pixel_intensity),
        .o_on_screen       (o_on_screen),
        .o_last            (o_last)
    );

`ifndef SYNTH
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.vec, w_cmd.step, w_cmd.scale_iter, w_cmd.sign, w_cmd.diff,
                  w_cmd.setup, w_cmd.inc_iter, w_cmd.fin, w_cmd.emit}))
        else $error("more than one datapath command at once");

    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_op == OP_VECTOR && i_intensity != 8'd0) |=> o_stall)
        else $error("drawing vector did not start the line setup");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_valid)
        else $error("emitted pixel not presented");

    a_pixel_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pixel_intensity != 8'd0)
        else $error("pixel from a line without intensity");
`endif

endmodule

// ===== tb/vector_dda_line_rasterizer_test.sv =====
module vector_dda_line_rasterizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import vdda_pkg::*;

    localparam int SCREEN   = DEFAULT_SCREEN_SIZE;
    localparam int HALF     = SCREEN / 2;
    localparam int SETTLE   = 64;     // longer than a drawing vector takes to emit its pixel
    localparam int WATCHDOG = 5000;
    localparam int N_ITEMS  = 1300;
    localparam int N_PHASES = 8;

    localparam logic [7:0] SCALE_SET [0:4] = '{8'd255, 8'd0, 8'd1, 8'd2, 8'd128};

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [7:0]         inten;
        logic               on;
        logic               last;
    } t_pixel;

    typedef struct packed {
        logic               op;
        logic signed [12:0] dx;
        logic signed [12:0] dy;
        logic [7:0]         inten;
        logic               fixed;
        logic               has;
        t_pixel             px;
    } t_stim_row;

    localparam t_pixel NO_PIX = '0;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_op = OP_VECTOR;
    logic signed [12:0] i_delta_x = '0;
    logic signed [12:0] i_delta_y = '0;
    logic [7:0]         i_intensity = '0;
    logic               i_scale_we = 1'b0;
    logic [7:0]         i_scale_wdata = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_pixel_x;
    logic signed [15:0] o_pixel_y;
    logic [7:0]         o_pixel_intensity;
    logic               o_on_screen;
    logic               o_last;

    // Line state mirrored from the block
    logic [7:0]  scale_r = SCALE_RESET;
    logic [15:0] bm_x = '0;
    logic [15:0] bm_y = '0;
    logic [31:0] pen_x = '0;
    logic [31:0] pen_y = '0;
    logic [17:0] inc_x = '0;
    logic [17:0] inc_y = '0;
    logic [15:0] pix_left = '0;
    logic [7:0]  ln_inten = '0;

    t_pixel pixel_q [$];
    t_pixel want_px;
    int     err_cnt = 0;
    int     idle_cycles = 0;
    int     burst_left = 0;
    int     stall_mode = 0;
    int     stall_run = 0;

    t_stim_row dir_tab [0:25] = '{
        // step with no line; unused fields at their extremes
        '{OP_STEP,   -13'sd4096, 13'sd4095, 8'd255, 1'b1, 1'b0, NO_PIX},
        // zero-length line: one pixel, last set
        '{OP_VECTOR, 13'sd0, 13'sd0, 8'd255, 1'b1, 1'b1,
          '{16'sd0, 16'sd0, 8'd255, 1'b1, 1'b1}},
        '{OP_STEP,   13'sd0, 13'sd0, 8'd0, 1'b1, 1'b0, NO_PIX},
        // negative minor axis, pen truncates toward zero
        '{OP_VECTOR, -13'sd10, -13'sd3, 8'd7, 1'b1, 1'b1,
          '{16'sd0, 16'sd0, 8'd7, 1'b1, 1'b0}},
        '{OP_STEP,   13'sd0, 13'sd0, 8'd0, 1'b0, 1'b0, NO_PIX},
        '{OP_STEP,   13'sd0, 13'sd0, 8'd0, 1'b0, 1'b0, NO_PIX},
        '{OP_STEP,   13'sd0, 13'sd0, 8'd0, 1'b0, 1'b0, NO_PIX},
        // move only, drops the unfinished line
        '{OP_VECTOR, 13'sd519, 13'sd2, 8'd0, 1'b1, 1'b0, NO_PIX},
        '{OP_STEP,   13'sd0, 13'sd0, 8'd0, 1'b1, 1'b0, NO_PIX},
        // ends one column past the right screen edge
        '{OP_VECTOR, 13'sd3, 13'sd1, 8'd1, 1'b1, 1'b1,
          '{16'sd509, -16'sd1, 8'd1, 1'b1, 1'b0}},
        '{OP_STEP,   13'sd0, 13'sd0, 8'd0, 1'b0, 1'b0, NO_PIX},
        '{OP_STEP,   13'sd0, 13'sd0, 8'd0, 1'b0, 1'b0, NO_PIX},
        '{OP_STEP,   13'sd0, 13'sd0, 8'd0, 1'b1, 1'b1,
          '{16'sd512, 16'sd0, 8'd1, 1'b0, 1'b1}},
        '{OP_STEP,   13'sd0, 13'sd0, 8'd0, 1'b1, 1'b0, NO_PIX},
        // walk the beam up toward the positive limit
        '{OP_VECTOR, 13'sd4095, 13'sd4095, 8'd0, 1'b1, 1'b0, NO_PIX},
        '{OP_VECTOR, 13'sd4095, 13'sd4095, 8'd0, 1'b1, 1'b0, NO_PIX},
        '{OP_VECTOR, 13'sd4095, 13'sd4095, 8'd0, 1'b1, 1'b0, NO_PIX},
        '{OP_VECTOR, 13'sd4095, 13'sd4095, 8'd0, 1'b1, 1'b0, NO_PIX},
        '{OP_VECTOR, 13'sd4095, 13'sd4095, 8'd0, 1'b1, 1'b0, NO_PIX},
        '{OP_VECTOR, 13'sd4095, 13'sd4095, 8'd0, 1'b1, 1'b0, NO_PIX},
        '{OP_VECTOR, 13'sd4095, 13'sd4095, 8'd0, 1'b1, 1'b0, NO_PIX},
        // beam x wraps past +32767, long line back across
        '{OP_VECTOR, 13'sd4095, 13'sd4095, 8'd255, 1'b0, 1'b0, NO_PIX},
        '{OP_STEP,   13'sd0, 13'sd0, 8'd0, 1'b0, 1'b0, NO_PIX},
        '{OP_STEP,   13'sd0, 13'sd0, 8'd0, 1'b0, 1'b0, NO_PIX},
        '{OP_VECTOR, -13'sd4096, -13'sd4096, 8'd128, 1'b0, 1'b0, NO_PIX},
        '{OP_STEP,   13'sd0, 13'sd0, 8'd0, 1'b0, 1'b0, NO_PIX}
    };

    vector_dda_line_rasterizer u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_op              (i_op),
        .i_delta_x         (i_delta_x),
        .i_delta_y         (i_delta_y),
        .i_intensity       (i_intensity),
        .i_scale_we        (i_scale_we),
        .i_scale_wdata     (i_scale_wdata),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_pixel_x         (o_pixel_x),
        .o_pixel_y         (o_pixel_y),
        .o_pixel_intensity (o_pixel_intensity),
        .o_on_screen       (o_on_screen),
        .o_last            (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Q2.16 slope |d|/n truncated, sign of d applied afterwards
    function automatic logic [17:0] slope_q16(input int d, input int n);
        longint q;
        q = (longint'(d < 0 ? -d : d) << 16) / longint'(n);
        if (d < 0) q = -q;
        return q[17:0];
    endfunction

    // Q16.16 to integer, toward zero
    function automatic int pen_whole(input logic [31:0] p);
        logic [31:0] mag;
        mag = p[31] ? (32'd0 - p) : p;
        return p[31] ? -int'(mag[31:16]) : int'(mag[31:16]);
    endfunction

    function automatic t_pixel pen_pixel(input logic last);
        t_pixel r;
        int     xi;
        int     yi;
        xi = pen_whole(pen_x);
        yi = pen_whole(pen_y);
        r.x     = xi[15:0];
        r.y     = yi[15:0];
        r.inten = ln_inten;
        r.on    = (xi + HALF >= 0) && (xi + HALF < SCREEN) &&
                  (yi + HALF >= 0) && (yi + HALF < SCREEN);
        r.last  = last;
        return r;
    endfunction

    task automatic trace_pixel(input logic op, input logic signed [12:0] ddx,
                               input logic signed [12:0] ddy, input logic [7:0] inten,
                               output logic made, output t_pixel px);
        int          div;
        int          x1;
        int          y1;
        int          x2;
        int          y2;
        int          dx;
        int          dy;
        int          ax;
        int          ay;
        int          span;
        logic [15:0] nx;
        logic [15:0] ny;
        made = 1'b0;
        px = NO_PIX;
        if (op == OP_VECTOR) begin
            div = (scale_r == 8'd0) ? 1 : int'(scale_r);
            nx = bm_x + {{3{ddx[12]}}, ddx};
            ny = bm_y + {{3{ddy[12]}}, ddy};
            x1 = int'($signed(bm_x)) / div;
            y1 = int'($signed(bm_y)) / div;
            x2 = int'($signed(nx)) / div;
            y2 = int'($signed(ny)) / div;
            bm_x = nx;
            bm_y = ny;
            pix_left = '0;
            if (inten != 8'd0) begin
                dx = x2 - x1;
                dy = y2 - y1;
                ax = dx < 0 ? -dx : dx;
                ay = dy < 0 ? -dy : dy;
                span = ax > ay ? ax : ay;
                ln_inten = inten;
                pen_x = {x1[15:0], 16'd0};
                pen_y = {y1[15:0], 16'd0};
                inc_x = (span == 0) ? '0 : slope_q16(dx, span);
                inc_y = (span == 0) ? '0 : slope_q16(dy, span);
                pix_left = span[15:0];
                made = 1'b1;
                px = pen_pixel(pix_left == 16'd0);
            end
        end else if (pix_left != 16'd0) begin
            pen_x = pen_x + {{14{inc_x[17]}}, inc_x};
            pen_y = pen_y + {{14{inc_y[17]}}, inc_y};
            pix_left = pix_left - 16'd1;
            made = 1'b1;
            px = pen_pixel(pix_left == 16'd0);
        end
    endtask

    // Drive one item, wait for its transfer, then record what it should produce.
    task automatic issue_item(input logic op, input logic signed [12:0] dx,
                              input logic signed [12:0] dy, input logic [7:0] inten,
                              input logic fixed, input logic fixed_has,
                              input t_pixel fixed_px);
        int     gap;
        logic   made;
        t_pixel px;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_op        <= op;
        i_delta_x   <= dx;
        i_delta_y   <= dy;
        i_intensity <= inten;
        @(posedge i_clk);
        while (!(i_valid && !o_stall)) @(posedge i_clk);
        trace_pixel(op, dx, dy, inten, made, px);
        if (fixed) begin
            made = fixed_has;
            px = fixed_px;
        end
        if (made) pixel_q.push_back(px);
    endtask

    // Hold off input until every pixel is out and the block has settled.
    task automatic drain_pixels();
        i_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_scale(input logic [7:0] v);
        drain_pixels();
        i_scale_we    <= 1'b1;
        i_scale_wdata <= v;
        @(posedge i_clk);
        i_scale_we <= 1'b0;
        scale_r = v;
    endtask

    // Pixel checker and stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pixel_q.size() == 0) begin
                $error("unexpected pixel x=%0d y=%0d", o_pixel_x, o_pixel_y);
                err_cnt++;
            end else begin
                want_px = pixel_q.pop_front();
                if (o_pixel_x !== want_px.x) begin
                    $error("pixel_x expected %0d got %0d", want_px.x, o_pixel_x);
                    err_cnt++;
                end
                if (o_pixel_y !== want_px.y) begin
                    $error("pixel_y expected %0d got %0d", want_px.y, o_pixel_y);
                    err_cnt++;
                end
                if (o_pixel_intensity !== want_px.inten) begin
                    $error("pixel_intensity expected %0d got %0d", want_px.inten,
                           o_pixel_intensity);
                    err_cnt++;
                end
                if (o_on_screen !== want_px.on) begin
                    $error("on_screen expected %0d got %0d", want_px.on, o_on_screen);
                    err_cnt++;
                end
                if (o_last !== want_px.last) begin
                    $error("last expected %0d got %0d", want_px.last, o_last);
                    err_cnt++;
                end
            end
        end
        if (stall_run == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run = $urandom_range(20, 300);
        end
        stall_run--;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= ~i_stall;
        endcase
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int                 phase_items;
        int                 lim;
        int                 n;
        logic signed [12:0] dx;
        logic signed [12:0] dy;
        logic [7:0]         inten;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            issue_item(dir_tab[k].op, dir_tab[k].dx, dir_tab[k].dy, dir_tab[k].inten,
                       dir_tab[k].fixed, dir_tab[k].has, dir_tab[k].px);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            write_scale(p < 5 ? SCALE_SET[p] : 8'($urandom_range(3, 254)));
            phase_items = 0;
            while (phase_items < N_ITEMS / N_PHASES) begin
                if ($urandom_range(0, 99) == 0) drain_pixels();
                case ($urandom_range(0, 3))
                    0: lim = 15;
                    1: lim = 255;
                    2: lim = 1023;
                    default: lim = 4095;
                endcase
                dx = 13'(int'($urandom_range(0, 2 * lim + 1)) - lim - 1);
                dy = 13'(int'($urandom_range(0, 2 * lim + 1)) - lim - 1);
                if ($urandom_range(0, 99) < 85) begin
                    // a line followed by its steps, sometimes cut short or overrun
                    inten = ($urandom_range(0, 6) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                    issue_item(OP_VECTOR, dx, dy, inten, 1'b0, 1'b0, NO_PIX);
                    n = int'(pix_left);
                    if (n > 40 || $urandom_range(0, 9) == 0)
                        n = $urandom_range(0, n > 40 ? 40 : n);
                    else
                        n = n + $urandom_range(0, 1);
                    repeat (n) begin
                        issue_item(OP_STEP, 13'($urandom), 13'($urandom), 8'($urandom),
                                   1'b0, 1'b0, NO_PIX);
                    end
                    phase_items += n + 1;
                end else begin
                    if ($urandom_range(0, 1) == 0)
                        issue_item(OP_STEP, 13'($urandom), 13'($urandom), 8'($urandom),
                                   1'b0, 1'b0, NO_PIX);
                    else
                        issue_item(OP_VECTOR, 13'($urandom), 13'($urandom), 8'd0,
                                   1'b0, 1'b0, NO_PIX);
                    phase_items++;
                end
            end
        end

        drain_pixels();
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/vdda_pkg.sv
rtl/vdda_ctrl.sv
rtl/vdda_datapath.sv
rtl/vector_dda_line_rasterizer.sv
tb/vector_dda_line_rasterizer_test.sv
